// ----- sv/mlz_pkg.sv -----
`timescale 1ns / 1ps

package mlz_pkg;

    // parser phases, one-hot
    typedef enum logic [11:0] {
        PH_FIRST    = 12'b0000_0000_0001,
        PH_FLAG     = 12'b0000_0000_0010,
        PH_OP       = 12'b0000_0000_0100,
        PH_SHORT3   = 12'b0000_0000_1000,
        PH_ZEROS    = 12'b0000_0001_0000,
        PH_LENBITS  = 12'b0000_0010_0000,
        PH_BIGFLAG  = 12'b0000_0100_0000,
        PH_BIGHI    = 12'b0000_1000_0000,
        PH_LIT      = 12'b0001_0000_0000,
        PH_DISP1    = 12'b0010_0000_0000,
        PH_BIGLONG  = 12'b0100_0000_0000,
        PH_BIGSHORT = 12'b1000_0000_0000
    } t_phase;

    typedef enum logic [1:0] {
        KIND_LITERAL = 2'd0,
        KIND_COPY    = 2'd1,
        KIND_END     = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  literal_value;
        logic [12:0] copy_distance;
        logic [8:0]  copy_length;
    } t_token;

    typedef struct packed {
        t_phase      phase;
        logic [7:0]  bit_buffer;
        logic [3:0]  bits_left;
        logic [1:0]  opcode_bits;
        logic [3:0]  zero_run;
        logic [6:0]  gathered_bits;
        logic [2:0]  bits_wanted;
        logic [8:0]  pending_length;
        logic [3:0]  disp_high;
        logic        stream_done;
    } t_state;

    localparam t_state STATE_RESET = '{
        phase: PH_FIRST, bit_buffer: 8'd0, bits_left: 4'd0, opcode_bits: 2'd0,
        zero_run: 4'd0, gathered_bits: 7'd0, bits_wanted: 3'd0,
        pending_length: 9'd0, disp_high: 4'd0, stream_done: 1'b0
    };

    localparam logic [12:0] DIST_LONG_BASE  = 13'h1100;
    localparam logic [12:0] DIST_SHORT_BASE = 13'd256;
    localparam logic [12:0] DIST_TINY_BASE  = 13'd8;

endpackage

// ----- sv/megalz_token_decoder.sv -----
`timescale 1ns / 1ps

// megalz token decoder
// slave channel: one packed byte per transaction on s_axis_tdata; s_axis_tuser
// set marks the first byte of a new packed stream and restarts the parser.
// master channel: one decoded token per transaction. m_axis_tuser is the token
// kind (literal, copy, end of stream), m_axis_tdata carries literal value,
// copy distance and copy length, m_axis_tlast marks the last token that one
// input byte produced. a byte can yield zero, one or two tokens.
// throughput: one byte per cycle while the token queue has room; the parser walks
// all eight bits of a byte combinationally. output is one token per cycle while the
// receiver is ready, so a run of bytes giving two tokens each fills the queue and slows intake.
// path: a byte passes the input register, then the token queue, before its first
// token reaches the master side.
// stalls: a four-entry token queue decouples the sides; a byte is parsed only
// when the queue has room for two tokens, otherwise it waits in the input
// register and s_axis_tready drops once that register is full.
// reset: parser returns to waiting for the first byte, queue empties.
module megalz_token_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // packed_byte[7:0]
    input  logic        s_axis_tuser,   // stream_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // literal_value[7:0], copy_distance[20:8],
                                        // copy_length[29:21], zero pad[31:30]
    output logic [1:0]  m_axis_tuser,   // token_kind[1:0]
    output logic        m_axis_tlast    // last_of_run
);

    typedef struct packed {
        mlz_pkg::t_token tok;
        logic            last;
    } t_entry;

    // input register
    logic            r_in_valid;
    logic [7:0]      r_in_byte;
    logic            r_in_start;

    // token queue
    t_entry          r_fifo [4];
    logic [1:0]      r_wr;
    logic [1:0]      r_rd;
    logic [2:0]      r_cnt;

    logic            w_pop;
    logic            w_fire;
    logic [2:0]      w_after_pop;
    logic [1:0]      w_count;
    mlz_pkg::t_token w_tok0;
    mlz_pkg::t_token w_tok1;
    t_entry          w_head;

    assign w_pop       = m_axis_tvalid && m_axis_tready;
    assign w_after_pop = r_cnt - {2'b00, w_pop};
    // parse only with room for the worst case of two tokens
    assign w_fire      = r_in_valid && (w_after_pop <= 3'd2);
    assign s_axis_tready = !r_in_valid || w_fire;

    mlz_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fire),
        .i_byte  (r_in_byte),
        .i_start (r_in_start),
        .o_count (w_count),
        .o_tok0  (w_tok0),
        .o_tok1  (w_tok1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte  <= s_axis_tdata;
            r_in_start <= s_axis_tuser;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 2'd0;
            r_rd  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            r_wr  <= r_wr + w_count;
            r_rd  <= r_rd + {1'b0, w_pop};
            r_cnt <= w_after_pop + {1'b0, w_count};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_count != 2'd0) begin
            r_fifo[r_wr] <= '{tok: w_tok0, last: (w_count == 2'd1)};
        end
        if (w_count == 2'd2) begin
            r_fifo[r_wr + 2'd1] <= '{tok: w_tok1, last: 1'b1};
        end
    end

    assign w_head        = r_fifo[r_rd];
    assign m_axis_tvalid = (r_cnt != 3'd0);
    assign m_axis_tdata  = {2'b00, w_head.tok.copy_length, w_head.tok.copy_distance,
                            w_head.tok.literal_value};
    assign m_axis_tuser  = w_head.tok.kind;
    assign m_axis_tlast  = w_head.last;

endmodule

// ----- sv/mlz_parse.sv -----
`timescale 1ns / 1ps

// parser state and the per-byte bit walk (up to eight bits per byte)
module mlz_parse (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [7:0]      i_byte,
    input  logic            i_start,
    output logic [1:0]      o_count,
    output mlz_pkg::t_token o_tok0,
    output mlz_pkg::t_token o_tok1
);

    localparam logic [1:0] OP_SHORT = 2'd0;
    localparam logic [1:0] OP_DISP1 = 2'd1;
    localparam logic [1:0] OP_LEN3  = 2'd2;
    localparam logic [1:0] OP_LONG  = 2'd3;
    localparam logic [3:0] ZR_END   = 4'd8;
    localparam logic [3:0] ZR_MAX   = 4'd15;
    localparam logic [3:0] ZR_LEN   = 4'd6;

    mlz_pkg::t_state r_state;
    mlz_pkg::t_state n_state;

    function automatic logic is_bit_phase(mlz_pkg::t_phase ph);
        return (ph == mlz_pkg::PH_FLAG)    || (ph == mlz_pkg::PH_OP) ||
               (ph == mlz_pkg::PH_SHORT3)  || (ph == mlz_pkg::PH_ZEROS) ||
               (ph == mlz_pkg::PH_LENBITS) || (ph == mlz_pkg::PH_BIGFLAG) ||
               (ph == mlz_pkg::PH_BIGHI);
    endfunction

    function automatic mlz_pkg::t_state take_bit(mlz_pkg::t_state s, logic bt);
        mlz_pkg::t_state n;
        n = s;
        unique case (s.phase)
            mlz_pkg::PH_FLAG: begin
                if (bt) begin
                    n.phase = mlz_pkg::PH_LIT;
                end else begin
                    n.phase       = mlz_pkg::PH_OP;
                    n.opcode_bits = 2'd0;
                    n.bits_wanted = 3'd2;
                end
            end
            mlz_pkg::PH_OP: begin
                n.opcode_bits = {s.opcode_bits[0], bt};
                n.bits_wanted = s.bits_wanted - 3'd1;
                if (n.bits_wanted == 3'd0) begin
                    case (n.opcode_bits)
                        OP_SHORT: begin
                            n.phase         = mlz_pkg::PH_SHORT3;
                            n.gathered_bits = 7'd0;
                            n.bits_wanted   = 3'd3;
                        end
                        OP_DISP1: n.phase = mlz_pkg::PH_DISP1;
                        OP_LEN3: begin
                            n.pending_length = 9'd3;
                            n.phase          = mlz_pkg::PH_BIGFLAG;
                        end
                        OP_LONG: begin
                            n.zero_run = 4'd0;
                            n.phase    = mlz_pkg::PH_ZEROS;
                        end
                        default: n.phase = s.phase;
                    endcase
                end
            end
            mlz_pkg::PH_SHORT3: begin
                n.gathered_bits = {s.gathered_bits[5:0], bt};
                n.bits_wanted   = s.bits_wanted - 3'd1;
                if (n.bits_wanted == 3'd0) begin
                    n.phase = mlz_pkg::PH_FLAG;
                end
            end
            mlz_pkg::PH_ZEROS: begin
                if (!bt) begin
                    if (s.zero_run != ZR_MAX) begin
                        n.zero_run = s.zero_run + 4'd1;
                    end
                end else if (s.zero_run == ZR_END) begin
                    n.stream_done = 1'b1;
                end else if (s.zero_run <= ZR_LEN) begin
                    n.phase         = mlz_pkg::PH_LENBITS;
                    n.gathered_bits = 7'd0;
                    n.bits_wanted   = s.zero_run[2:0] + 3'd1;
                end else begin
                    // zero run of 7 or 9+ is a no-op
                    n.phase = mlz_pkg::PH_FLAG;
                end
            end
            mlz_pkg::PH_LENBITS: begin
                n.gathered_bits = {s.gathered_bits[5:0], bt};
                n.bits_wanted   = s.bits_wanted - 3'd1;
                if (n.bits_wanted == 3'd0) begin
                    n.pending_length = 9'd2 + (9'd1 << (s.zero_run[2:0] + 3'd1))
                                     + {2'b00, n.gathered_bits};
                    n.phase = mlz_pkg::PH_BIGFLAG;
                end
            end
            mlz_pkg::PH_BIGFLAG: begin
                if (bt) begin
                    n.disp_high   = 4'd0;
                    n.bits_wanted = 3'd4;
                    n.phase       = mlz_pkg::PH_BIGHI;
                end else begin
                    n.phase = mlz_pkg::PH_BIGSHORT;
                end
            end
            mlz_pkg::PH_BIGHI: begin
                n.disp_high   = {s.disp_high[2:0], bt};
                n.bits_wanted = s.bits_wanted - 3'd1;
                if (n.bits_wanted == 3'd0) begin
                    n.phase = mlz_pkg::PH_BIGLONG;
                end
            end
            default: n = s;
        endcase
        return n;
    endfunction

    always_comb begin
        mlz_pkg::t_state s;
        mlz_pkg::t_token tok;
        logic            bt;
        logic            hit;
        logic [1:0]      cnt;
        mlz_pkg::t_token res0;
        mlz_pkg::t_token res1;

        s    = i_start ? mlz_pkg::STATE_RESET : r_state;
        cnt  = 2'd0;
        res0 = '0;
        res1 = '0;
        tok  = '0;
        bt   = 1'b0;
        hit  = 1'b0;

        if (i_valid && !s.stream_done) begin
            if (is_bit_phase(s.phase)) begin
                s.bit_buffer = i_byte;
                s.bits_left  = 4'd8;
            end else begin
                tok      = '0;
                tok.kind = mlz_pkg::KIND_COPY;
                unique case (s.phase)
                    mlz_pkg::PH_LIT: begin
                        tok.kind          = mlz_pkg::KIND_LITERAL;
                        tok.literal_value = i_byte;
                    end
                    mlz_pkg::PH_DISP1: begin
                        tok.copy_distance = mlz_pkg::DIST_SHORT_BASE - {5'd0, i_byte};
                        tok.copy_length   = 9'd2;
                    end
                    mlz_pkg::PH_BIGLONG: begin
                        tok.copy_distance = mlz_pkg::DIST_LONG_BASE
                                          - {1'b0, s.disp_high, 8'd0} - {5'd0, i_byte};
                        tok.copy_length   = s.pending_length;
                    end
                    mlz_pkg::PH_BIGSHORT: begin
                        tok.copy_distance = mlz_pkg::DIST_SHORT_BASE - {5'd0, i_byte};
                        tok.copy_length   = s.pending_length;
                    end
                    default: begin
                        // first byte of a stream is a plain literal
                        tok.kind          = mlz_pkg::KIND_LITERAL;
                        tok.literal_value = i_byte;
                        s.bits_left       = 4'd0;
                    end
                endcase
                res0    = tok;
                cnt     = 2'd1;
                s.phase = mlz_pkg::PH_FLAG;
            end

            for (int i = 0; i < 8; i++) begin
                if (!s.stream_done && is_bit_phase(s.phase) && s.bits_left != 4'd0) begin
                    bt          = s.bit_buffer[7];
                    s.bit_buffer = {s.bit_buffer[6:0], 1'b0};
                    s.bits_left = s.bits_left - 4'd1;
                    tok         = '0;
                    hit         = 1'b0;
                    if (s.phase == mlz_pkg::PH_SHORT3 && s.bits_wanted == 3'd1) begin
                        tok.kind          = mlz_pkg::KIND_COPY;
                        tok.copy_distance = mlz_pkg::DIST_TINY_BASE
                                          - {10'd0, s.gathered_bits[1:0], bt};
                        tok.copy_length   = 9'd1;
                        hit               = 1'b1;
                    end else if (s.phase == mlz_pkg::PH_ZEROS && bt &&
                                 s.zero_run == ZR_END) begin
                        tok.kind = mlz_pkg::KIND_END;
                        hit      = 1'b1;
                    end
                    if (hit) begin
                        if (cnt == 2'd0) begin
                            res0 = tok;
                        end else if (cnt == 2'd1) begin
                            res1 = tok;
                        end
                        if (cnt != 2'd2) begin
                            cnt = cnt + 2'd1;
                        end
                    end
                    s = take_bit(s, bt);
                end
            end
        end

        n_state = i_valid ? s : r_state;
        o_count = cnt;
        o_tok0  = res0;
        o_tok1  = res1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mlz_pkg::STATE_RESET;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- tb/sv/megalz_token_decoder_tb.sv -----
`timescale 1ns / 1ps

// megalz token decoder testbench
// a small packer inside the bench builds packed streams token by token, interleaving
// flag bytes and data bytes in the order the decoder reads them. every accepted byte
// is run through a bit-exact decoder model that queues the tokens it must produce.
// the master side is checked field by field against that queue.
module megalz_token_decoder_tb;

    localparam int RESET_CYCLES   = 7;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 30;

    // opcodes after a zero flag bit
    localparam logic [1:0] OP_SHORT = 2'd0;  // 3-bit distance, length 1
    localparam logic [1:0] OP_DISP1 = 2'd1;  // byte distance, length 2
    localparam logic [1:0] OP_LEN3  = 2'd2;  // displacement, length 3
    localparam logic [1:0] OP_LONG  = 2'd3;  // zero-run length prefix

    localparam int ZERO_RUN_END  = 8;   // zero run that marks the end of stream
    localparam int ZERO_RUN_NOOP = 7;   // zero run that yields no token
    localparam int ZERO_RUN_MAX  = 15;  // zero counter saturates here
    localparam int ZERO_RUN_LEN  = 6;   // longest run that still gives a length

    localparam logic [12:0] DIST_LONG  = 13'h1100;
    localparam logic [12:0] DIST_SHORT = 13'd256;
    localparam logic [12:0] DIST_TINY  = 13'd8;

    typedef struct {
        mlz_pkg::t_kind kind;
        logic [7:0]     lit;
        logic [12:0]    distance;
        logic [8:0]     len;
        logic           last;
    } t_exp_tok;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'd0;   // packed_byte[7:0]
    logic        s_axis_tuser  = 1'b0;   // stream_start
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;           // literal[7:0], distance[20:8], length[29:21]
    logic [1:0]  m_axis_tuser;           // token_kind[1:0]
    logic        m_axis_tlast;           // last_of_run

    // decoder model state
    mlz_pkg::t_phase dec_phase;
    logic [7:0]  dec_buf;
    logic [3:0]  dec_left;
    logic [1:0]  dec_op;
    logic [3:0]  dec_zeros;
    logic [6:0]  dec_gather;
    logic [2:0]  dec_want;
    logic [8:0]  dec_len;
    logic [3:0]  dec_hi;
    logic        dec_done;

    t_exp_tok    run_tokens[$];   // tokens of the byte being decoded
    t_exp_tok    tokens_due[$];   // tokens the block still owes us

    // packer state
    logic [7:0]  pk_bytes[$];
    int          pk_flag_idx;
    int          pk_free;

    int          errors         = 0;
    int          tokens_checked = 0;
    int          bytes_parsed   = 0;
    int          streams_sent   = 0;
    int          idle_cycles    = 0;
    int          rx_hold        = 0;
    bit          no_gaps        = 1'b0;

    megalz_token_decoder u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #6 i_clk = ~i_clk;

    // ---------------------------------------------------------------- decoder model

    function automatic void dec_reset();
        dec_phase  = mlz_pkg::PH_FIRST;
        dec_buf    = '0;
        dec_left   = '0;
        dec_op     = '0;
        dec_zeros  = '0;
        dec_gather = '0;
        dec_want   = '0;
        dec_len    = '0;
        dec_hi     = '0;
        dec_done   = 1'b0;
    endfunction

    function automatic bit in_bit_phase();
        return dec_phase inside {mlz_pkg::PH_FLAG, mlz_pkg::PH_OP, mlz_pkg::PH_SHORT3,
                                 mlz_pkg::PH_ZEROS, mlz_pkg::PH_LENBITS,
                                 mlz_pkg::PH_BIGFLAG, mlz_pkg::PH_BIGHI};
    endfunction

    function automatic void add_token(mlz_pkg::t_kind kind, logic [7:0] lit,
                                      logic [12:0] distance, logic [8:0] len);
        t_exp_tok t;
        if (run_tokens.size() >= 2) return;
        t.kind     = kind;
        t.lit      = lit;
        t.distance = distance;
        t.len      = len;
        t.last     = 1'b0;
        run_tokens.push_back(t);
    endfunction

    // one bit of the flag stream, msb first
    function automatic void take_bit(logic b);
        case (dec_phase)
            mlz_pkg::PH_FLAG: begin
                if (b) begin
                    dec_phase = mlz_pkg::PH_LIT;
                end else begin
                    dec_phase = mlz_pkg::PH_OP;
                    dec_op    = '0;
                    dec_want  = 3'd2;
                end
            end
            mlz_pkg::PH_OP: begin
                dec_op   = {dec_op[0], b};
                dec_want = dec_want - 3'd1;
                if (dec_want == 3'd0) begin
                    case (dec_op)
                        OP_SHORT: begin
                            dec_phase  = mlz_pkg::PH_SHORT3;
                            dec_gather = '0;
                            dec_want   = 3'd3;
                        end
                        OP_DISP1: dec_phase = mlz_pkg::PH_DISP1;
                        OP_LEN3: begin
                            dec_len   = 9'd3;
                            dec_phase = mlz_pkg::PH_BIGFLAG;
                        end
                        default: begin
                            dec_zeros = '0;
                            dec_phase = mlz_pkg::PH_ZEROS;
                        end
                    endcase
                end
            end
            mlz_pkg::PH_SHORT3: begin
                dec_gather = {dec_gather[5:0], b};
                dec_want   = dec_want - 3'd1;
                if (dec_want == 3'd0) begin
                    add_token(mlz_pkg::KIND_COPY, '0, DIST_TINY - 13'(dec_gather[2:0]),
                              9'd1);
                    dec_phase = mlz_pkg::PH_FLAG;
                end
            end
            mlz_pkg::PH_ZEROS: begin
                if (!b) begin
                    if (dec_zeros != 4'(ZERO_RUN_MAX)) dec_zeros = dec_zeros + 4'd1;
                end else if (dec_zeros == 4'(ZERO_RUN_END)) begin
                    add_token(mlz_pkg::KIND_END, '0, '0, '0);
                    dec_done = 1'b1;
                end else if (dec_zeros <= 4'(ZERO_RUN_LEN)) begin
                    dec_phase  = mlz_pkg::PH_LENBITS;
                    dec_gather = '0;
                    dec_want   = dec_zeros[2:0] + 3'd1;
                end else begin
                    // no-op run, back to a flag bit
                    dec_phase = mlz_pkg::PH_FLAG;
                end
            end
            mlz_pkg::PH_LENBITS: begin
                dec_gather = {dec_gather[5:0], b};
                dec_want   = dec_want - 3'd1;
                if (dec_want == 3'd0) begin
                    dec_len   = 9'd2 + (9'd1 << (dec_zeros + 4'd1)) + 9'(dec_gather);
                    dec_phase = mlz_pkg::PH_BIGFLAG;
                end
            end
            mlz_pkg::PH_BIGFLAG: begin
                if (b) begin
                    dec_hi    = '0;
                    dec_want  = 3'd4;
                    dec_phase = mlz_pkg::PH_BIGHI;
                end else begin
                    dec_phase = mlz_pkg::PH_BIGSHORT;
                end
            end
            mlz_pkg::PH_BIGHI: begin
                dec_hi   = {dec_hi[2:0], b};
                dec_want = dec_want - 3'd1;
                if (dec_want == 3'd0) dec_phase = mlz_pkg::PH_BIGLONG;
            end
            default: ;
        endcase
    endfunction

    // decode one accepted byte and queue the tokens it yields
    function automatic void decode_byte(logic [7:0] b, logic start);
        t_exp_tok t;
        if (start) dec_reset();
        if (dec_done) return;
        bytes_parsed++;
        run_tokens.delete();
        if (in_bit_phase()) begin
            dec_buf  = b;
            dec_left = 4'd8;
        end else begin
            case (dec_phase)
                mlz_pkg::PH_LIT:
                    add_token(mlz_pkg::KIND_LITERAL, b, '0, '0);
                mlz_pkg::PH_DISP1:
                    add_token(mlz_pkg::KIND_COPY, '0, DIST_SHORT - 13'(b), 9'd2);
                mlz_pkg::PH_BIGLONG:
                    add_token(mlz_pkg::KIND_COPY, '0,
                              DIST_LONG - {1'b0, dec_hi, 8'd0} - 13'(b), dec_len);
                mlz_pkg::PH_BIGSHORT:
                    add_token(mlz_pkg::KIND_COPY, '0, DIST_SHORT - 13'(b), dec_len);
                default: begin
                    // first byte of a stream is a plain literal
                    add_token(mlz_pkg::KIND_LITERAL, b, '0, '0);
                    dec_left = '0;
                end
            endcase
            dec_phase = mlz_pkg::PH_FLAG;
        end
        while (!dec_done && in_bit_phase() && dec_left != 4'd0) begin
            take_bit(dec_buf[7]);
            dec_buf  = dec_buf << 1;
            dec_left = dec_left - 4'd1;
        end
        foreach (run_tokens[i]) begin
            t      = run_tokens[i];
            t.last = (i == run_tokens.size() - 1);
            tokens_due.push_back(t);
        end
    endfunction

    // ---------------------------------------------------------------- packer

    function automatic void pk_begin(logic [7:0] first);
        pk_bytes.delete();
        pk_bytes.push_back(first);
        pk_free = 0;
    endfunction

    // a new flag byte is reserved at the current position when the old one is used up;
    // unused flag bits stay random
    function automatic void pk_bit(logic b);
        logic [7:0] fb;
        if (pk_free == 0) begin
            pk_flag_idx = pk_bytes.size();
            pk_bytes.push_back(8'($urandom));
            pk_free = 8;
        end
        fb = pk_bytes[pk_flag_idx];
        fb[pk_free - 1] = b;
        pk_bytes[pk_flag_idx] = fb;
        pk_free--;
    endfunction

    function automatic void pk_field(logic [7:0] v, int width);
        for (int i = width - 1; i >= 0; i--) pk_bit(v[i]);
    endfunction

    function automatic void pk_byte(logic [7:0] v);
        pk_bytes.push_back(v);
    endfunction

    function automatic void pk_literal(logic [7:0] v);
        pk_bit(1'b1);
        pk_byte(v);
    endfunction

    function automatic void pk_opcode(logic [1:0] op);
        pk_bit(1'b0);
        pk_field(8'(op), 2);
    endfunction

    function automatic void pk_zeros(int n);
        repeat (n) pk_bit(1'b0);
        pk_bit(1'b1);
    endfunction

    function automatic void pk_disp(logic far, logic [3:0] hi, logic [7:0] lo);
        pk_bit(far);
        if (far) pk_field(8'(hi), 4);
        pk_byte(lo);
    endfunction

    function automatic void pk_end();
        pk_opcode(OP_LONG);
        pk_zeros(ZERO_RUN_END);
    endfunction

    function automatic void pk_random_token();
        int r;
        int k;
        r = $urandom_range(0, 99);
        if (r < 35) begin
            pk_literal(8'($urandom));
        end else if (r < 50) begin
            pk_opcode(OP_SHORT);
            pk_field(8'($urandom), 3);
        end else if (r < 65) begin
            pk_opcode(OP_DISP1);
            pk_byte(8'($urandom));
        end else if (r < 77) begin
            pk_opcode(OP_LEN3);
            pk_disp(1'($urandom), 4'($urandom), 8'($urandom));
        end else if (r < 95) begin
            k = $urandom_range(0, ZERO_RUN_LEN);
            pk_opcode(OP_LONG);
            pk_zeros(k);
            pk_field(8'($urandom), k + 1);
            pk_disp(1'($urandom), 4'($urandom), 8'($urandom));
        end else begin
            // no-op runs, including ones long enough to saturate the counter
            pk_opcode(OP_LONG);
            pk_zeros(($urandom_range(0, 3) == 0) ? ZERO_RUN_NOOP : $urandom_range(9, 20));
        end
    endfunction

    // ---------------------------------------------------------------- idling

    function automatic int stall_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // receiver: ready bursts and stalls of random length
    always @(posedge i_clk) begin
        if (no_gaps) begin
            m_axis_tready <= 1'b1;
            rx_hold       <= 0;
        end else if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
        end else if ($urandom_range(0, 99) < 65) begin
            m_axis_tready <= 1'b1;
            rx_hold       <= $urandom_range(0, 7);
        end else begin
            m_axis_tready <= 1'b0;
            rx_hold       <= stall_len() - 1;
        end
    end

    // ---------------------------------------------------------------- driving

    // one byte transaction; called and returning at a rising edge
    task automatic send_byte(input logic [7:0] b, input logic start);
        int gap;
        gap = (no_gaps || $urandom_range(0, 1) == 0) ? 0 : stall_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= start;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        decode_byte(b, start);
    endtask

    task automatic send_stream(input int count, input logic first_start);
        for (int i = 0; i < count; i++) send_byte(pk_bytes[i], (i == 0) ? first_start : 1'b0);
        streams_sent++;
    endtask

    // ---------------------------------------------------------------- checking

    function automatic void check_field(string name, logic [12:0] want, logic [12:0] got);
        if (got === want) return;
        errors++;
        if (errors <= MAX_REPORTS)
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    endfunction

    always @(posedge i_clk) begin
        t_exp_tok want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (tokens_due.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t ns: unexpected token, expected none, got kind %0d data %h",
                             $time, m_axis_tuser, m_axis_tdata);
            end else begin
                want = tokens_due.pop_front();
                tokens_checked++;
                check_field("kind", 13'(want.kind), 13'(m_axis_tuser));
                check_field("literal", 13'(want.lit), 13'(m_axis_tdata[7:0]));
                check_field("distance", want.distance, m_axis_tdata[20:8]);
                check_field("length", 13'(want.len), 13'(m_axis_tdata[29:21]));
                check_field("pad", 13'd0, 13'(m_axis_tdata[31:30]));
                check_field("last", 13'(want.last), 13'(m_axis_tlast));
            end
        end
    end

    // watchdog: no transaction on either side for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: no transaction for %0d cycles", $time, idle_cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------- tests

    // every code with its field extremes; first byte goes in without stream_start
    task automatic test_codes();
        pk_begin(8'h00);
        pk_literal(8'hFF);
        pk_opcode(OP_SHORT);
        pk_field(8'd0, 3);                     // distance 8
        pk_opcode(OP_SHORT);
        pk_field(8'd7, 3);                     // distance 1
        pk_opcode(OP_DISP1);
        pk_byte(8'h00);                        // distance 256
        pk_opcode(OP_LEN3);
        pk_disp(1'b1, 4'hF, 8'hFF);            // shortest long displacement
        pk_opcode(OP_LONG);
        pk_zeros(ZERO_RUN_LEN);
        pk_field(8'h7F, ZERO_RUN_LEN + 1);     // length 257
        pk_disp(1'b1, 4'h0, 8'h00);            // distance 4352
        pk_opcode(OP_LONG);
        pk_zeros(0);
        pk_field(8'h00, 1);                    // length 4
        pk_disp(1'b0, 4'h0, 8'hFF);
        pk_end();
        send_stream(pk_bytes.size(), 1'b0);
    endtask

    // no-op zero runs, a saturating run, end mark and bytes after it
    task automatic test_zero_runs();
        pk_begin(8'h81);
        pk_opcode(OP_LONG);
        pk_zeros(ZERO_RUN_NOOP);
        pk_opcode(OP_LONG);
        pk_zeros(17);
        pk_literal(8'h3C);
        pk_end();
        pk_byte(8'hFF);
        pk_byte(8'h00);
        send_stream(pk_bytes.size(), 1'b1);
    endtask

    // stream_start while a displacement byte is awaited
    task automatic test_restart();
        pk_begin(8'h5A);
        pk_literal(8'hC3);
        pk_opcode(OP_DISP1);
        pk_byte(8'h10);
        send_stream(3, 1'b1);
        pk_begin(8'h01);
        pk_end();
        send_stream(pk_bytes.size(), 1'b1);
    endtask

    // well-formed streams with random content, some cut short
    task automatic test_random_streams(input int target);
        int n_tok;
        int cut;
        while (bytes_parsed < target) begin
            no_gaps = ($urandom_range(0, 3) == 0);
            pk_begin(8'($urandom));
            n_tok = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 16);
            repeat (n_tok) pk_random_token();
            if ($urandom_range(0, 7) == 0) begin
                cut = $urandom_range(1, pk_bytes.size());
            end else begin
                pk_end();
                repeat ($urandom_range(0, 2)) pk_byte(8'($urandom));
                cut = pk_bytes.size();
            end
            send_stream(cut, 1'b1);
        end
        no_gaps = 1'b0;
    endtask

    // raw random bytes with an occasional restart
    task automatic test_noise(input int count);
        repeat (count) send_byte(8'($urandom), ($urandom_range(0, 24) == 0));
    endtask

    initial begin
        dec_reset();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_codes();
        test_zero_runs();
        test_restart();
        test_random_streams(560);
        test_noise(140);

        s_axis_tvalid <= 1'b0;
        no_gaps = 1'b1;
        while (tokens_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("decoded %0d live bytes over %0d streams plus random noise",
                 bytes_parsed, streams_sent);
        $display("compared %0d tokens, %0d field mismatches", tokens_checked, errors);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
